FILE: design/qsws_pkg.sv
// Shared types and constants for the QUIC short-header worker steering block.
// Used by qsws_ctrl, qsws_datapath and the top level; no dependencies.
package qsws_pkg;

  // MurmurHash2 multiplier
  localparam logic [31:0] MUR_M = 32'h5bd1e995;

  // Configuration register indexes
  localparam logic [1:0] CFG_CAPTURE = 2'd0;
  localparam logic [1:0] CFG_SALT_LEN = 2'd1;
  localparam logic [1:0] CFG_WORD_OFF = 2'd2;
  localparam logic [1:0] CFG_XOR_MASK = 2'd3;

  // Verdict codes
  localparam logic [1:0] VERDICT_STEER = 2'd0;
  localparam logic [1:0] VERDICT_CAPOFF = 2'd1;
  localparam logic [1:0] VERDICT_NOTSHORT = 2'd2;
  localparam logic [1:0] VERDICT_TRUNC = 2'd3;

  // Multiplier operand select
  localparam logic [2:0] MS_HASH = 3'd0;  // hash * M
  localparam logic [2:0] MS_BLOCK = 3'd1;  // block * M
  localparam logic [2:0] MS_KMIX = 3'd2;  // (k ^ k>>24) * M
  localparam logic [2:0] MS_TAIL = 3'd3;  // (hash ^ tail block) * M
  localparam logic [2:0] MS_FMIX_MUL = 3'd4;  // (h ^ h>>13) * M, h from product
  localparam logic [2:0] MS_FMIX_HASH = 3'd5;  // (h ^ h>>13) * M, h from hash

  typedef struct packed {
    logic       byte_en;   // request accepted this cycle
    logic       mul_en;    // load product register
    logic [2:0] mul_sel;   // operand select
    logic       tmp_en;    // save product into temp
    logic       hash_upd;  // fold block into hash, clear block
    logic       out_load;  // load result register
  } dp_cmd_t;

  typedef struct packed {
    logic blk_done;  // incoming byte completes a hash block
    logic steer;     // incoming byte would yield a steer verdict
    logic tail;      // salt length leaves a partial block
  } dp_status_t;

endpackage

FILE: design/qsws_datapath.sv
// Datapath: configuration registers, byte gathering, shared multiplier
// and result register. Depends on qsws_pkg; driven by qsws_ctrl.
module qsws_datapath #(
  parameter int MAX_SALT_BYTES = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  logic [7:0]           payload_byte,
  input  logic                 packet_end,
  input  qsws_pkg::dp_cmd_t    cmd,
  output qsws_pkg::dp_status_t status,
  output logic [1:0]           verdict,
  output logic [21:0]          worker_id
);
  import qsws_pkg::*;

  logic        cap_en_r;
  logic [4:0]  salt_len_r;
  logic [7:0]  word_off_r;
  logic [31:0] xor_mask_r;

  logic [8:0]  pos_r;
  logic [31:0] hash_r;
  logic [31:0] blk_r;
  logic [31:0] ww_r;
  logic        short_r;
  logic [1:0]  verdict_r;
  logic [31:0] mul_r;
  logic [31:0] tmp_r;
  logic [1:0]  out_verdict_r;
  logic [21:0] out_wid_r;

  logic [4:0]  eff_len;
  logic        pos_zero;
  logic [9:0]  d_w;
  logic [9:0]  count;
  logic [9:0]  off_w;
  logic [1:0]  lane;
  logic        in_salt;
  logic        in_word;
  logic        short_now;
  logic        trunc;
  logic [1:0]  verdict_now;
  logic [31:0] blk_nxt;
  logic [31:0] mul_src;
  logic [31:0] fmix_h;
  logic [31:0] fin_h;
  logic [31:0] wid_calc;
  logic [8:0]  pos_nxt;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_en_r   <= 1'b0;
      salt_len_r <= '0;
      word_off_r <= '0;
      xor_mask_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAPTURE:  cap_en_r   <= cfg_wdata[0];
        CFG_SALT_LEN: salt_len_r <= cfg_wdata[4:0];
        CFG_WORD_OFF: word_off_r <= cfg_wdata[7:0];
        CFG_XOR_MASK: xor_mask_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Salt length clamp
  assign eff_len = ({1'b0, salt_len_r} > 6'(MAX_SALT_BYTES)) ?
                   5'(MAX_SALT_BYTES) : salt_len_r;

  // Byte position decode
  assign pos_zero = (pos_r == 9'd0);
  assign d_w      = {1'b0, pos_r} - 10'd1;
  assign count    = {1'b0, pos_r} + 10'd1;
  assign off_w    = {2'b00, word_off_r};
  assign lane     = d_w[1:0];
  assign in_salt  = !pos_zero && (d_w < {5'b0, eff_len});
  assign in_word  = !pos_zero && (d_w >= off_w) && (d_w < off_w + 10'd4);
  assign blk_nxt  = blk_r | ({24'b0, payload_byte} << {lane, 3'b000});
  assign pos_nxt  = (pos_r == 9'd511) ? pos_r : count[8:0];

  // Verdict as of the incoming byte
  assign short_now = pos_zero ? (payload_byte[7:6] == 2'b01) : short_r;
  assign trunc     = (count < {5'b0, eff_len} + 10'd1) || (count < off_w + 10'd5);
  always_comb begin
    if (!cap_en_r)       verdict_now = VERDICT_CAPOFF;
    else if (!short_now) verdict_now = VERDICT_NOTSHORT;
    else if (trunc)      verdict_now = VERDICT_TRUNC;
    else                 verdict_now = VERDICT_STEER;
  end

  assign status.blk_done = in_salt && (lane == 2'd3);
  assign status.steer    = (verdict_now == VERDICT_STEER);
  assign status.tail     = (eff_len[1:0] != 2'd0);

  // Per-byte state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      hash_r    <= '0;
      blk_r     <= '0;
      ww_r      <= '0;
      short_r   <= 1'b0;
      verdict_r <= VERDICT_CAPOFF;
    end else if (cmd.byte_en) begin
      verdict_r <= verdict_now;
      pos_r     <= packet_end ? 9'd0 : pos_nxt;
      if (pos_zero) begin
        short_r <= short_now;
        hash_r  <= {27'b0, eff_len};
        blk_r   <= '0;
        ww_r    <= '0;
      end else begin
        if (in_salt) blk_r <= blk_nxt;
        if (in_word) ww_r <= {ww_r[23:0], payload_byte};
      end
    end else if (cmd.hash_upd) begin
      hash_r <= tmp_r ^ mul_r;
      blk_r  <= '0;
    end
  end

  // Shared multiplier operand
  assign fmix_h = (cmd.mul_sel == MS_FMIX_MUL) ? mul_r : hash_r;
  always_comb begin
    case (cmd.mul_sel)
      MS_HASH:      mul_src = hash_r;
      MS_BLOCK:     mul_src = blk_r;
      MS_KMIX:      mul_src = mul_r ^ (mul_r >> 24);
      MS_TAIL:      mul_src = hash_r ^ blk_r;
      MS_FMIX_MUL,
      MS_FMIX_HASH: mul_src = fmix_h ^ (fmix_h >> 13);
      default:      mul_src = hash_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) mul_r <= mul_src * MUR_M;
    if (cmd.tmp_en) tmp_r <= mul_r;
  end

  // Final mix and worker id
  assign fin_h    = mul_r ^ (mul_r >> 15);
  assign wid_calc = (ww_r ^ xor_mask_r) - fin_h;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_verdict_r <= verdict_r;
      out_wid_r     <= (verdict_r == VERDICT_STEER) ? wid_calc[21:0] : 22'd0;
    end
  end

  assign verdict   = out_verdict_r;
  assign worker_id = out_wid_r;

endmodule

FILE: design/qsws_ctrl.sv
// Controller: sequences the shared multiplier per hash block and per
// packet end, and owns the result handshake. Depends on qsws_pkg.
module qsws_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  qsws_pkg::dp_status_t status,
  output qsws_pkg::dp_cmd_t    cmd
);
  import qsws_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_B1   = 3'd1;
  localparam logic [2:0] S_B2   = 3'd2;
  localparam logic [2:0] S_B3   = 3'd3;
  localparam logic [2:0] S_B4   = 3'd4;
  localparam logic [2:0] S_FA   = 3'd5;
  localparam logic [2:0] S_FB   = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       last_r, last_nxt;
  logic       steer_r, steer_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;
  logic       steer_now;
  logic [2:0] end_state;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  // Steer decision: fresh from the datapath on a byte, held otherwise
  assign steer_now = (state_r == S_IDLE) ? status.steer : steer_r;

  // Where a packet goes after its last byte
  always_comb begin
    if (!steer_now)       end_state = S_DONE;
    else if (status.tail) end_state = S_FA;
    else                  end_state = S_FB;
  end

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    steer_nxt = steer_r;
    cmd       = '0;
    cmd.mul_sel = MS_HASH;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.byte_en = 1'b1;
          last_nxt    = in_tlast;
          steer_nxt   = status.steer;
          if (status.blk_done) state_nxt = S_B1;
          else if (in_tlast)   state_nxt = end_state;
        end
      end
      // hash * M
      S_B1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_HASH;
        state_nxt   = S_B2;
      end
      // keep hash * M, start block * M
      S_B2: begin
        cmd.tmp_en  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_BLOCK;
        state_nxt   = S_B3;
      end
      S_B3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_KMIX;
        state_nxt   = S_B4;
      end
      S_B4: begin
        cmd.hash_upd = 1'b1;
        state_nxt    = last_r ? end_state : S_IDLE;
      end
      S_FA: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_TAIL;
        state_nxt   = S_FB;
      end
      S_FB: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = status.tail ? MS_FMIX_MUL : MS_FMIX_HASH;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid: set on load, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)                   out_valid_nxt = 1'b1;
    else if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_r      <= 1'b0;
      steer_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      steer_r     <= steer_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: design/quic_short_header_worker_steer.sv
// QUIC short-header worker steering, top level.
// Depends on qsws_pkg, qsws_ctrl and qsws_datapath.
//
// Input stream: one UDP payload byte per request on in_tdata, in_tlast on
// the last byte of the packet. Output stream: one verdict per packet on
// out_tdata (verdict, then 22-bit worker id). The user must write the
// configuration registers through cfg_we / cfg_index / cfg_wdata only
// while the block is idle; the block itself does not enforce this.
// Input flow: a byte is taken when in_tvalid and in_tready are both high. A
// byte that completes a 4-byte salt block holds in_tready low while the
// single shared 32x32 multiplier runs the block mix (hash*M, k*M, mix*M,
// fold). After the last byte of a packet the multiplier runs the final mix
// when the packet is steered (a tail step before the fmix step when the
// salt length is not a multiple of 4), then the result register is loaded
// once the output is free.
// While a result waits for out_tready the next packet's bytes are still
// taken; a further result waits in the controller until the output frees.
// Reset (rst_n low, synchronous) clears the configuration registers, the
// packet state, the byte position and the output valid.
module quic_short_header_worker_steer #(
  parameter int MAX_SALT_BYTES = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] payload_byte
  input  logic        in_tlast,   // packet_end
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [1:0] verdict, [23:2] worker_id
);
  import qsws_pkg::*;

  dp_cmd_t     cmd;
  dp_status_t  status;
  logic [1:0]  verdict;
  logic [21:0] worker_id;

  qsws_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  qsws_datapath #(
    .MAX_SALT_BYTES (MAX_SALT_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .payload_byte (in_tdata),
    .packet_end   (in_tlast),
    .cmd          (cmd),
    .status       (status),
    .verdict      (verdict),
    .worker_id    (worker_id)
  );

  assign out_tdata = {worker_id, verdict};

  // A result is never loaded while a byte is being taken
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !in_tready)
    else $error("result load overlaps byte accept");

  // A loaded result is presented next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid)
    else $error("loaded result not presented");

  // Only steered packets carry a worker id
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[1:0] != VERDICT_STEER)) |-> (out_tdata[23:2] == 22'd0))
    else $error("worker id on non-steer verdict");

  // The multiplier is idle while bytes are taken
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.byte_en |-> !cmd.mul_en)
    else $error("multiplier busy during byte accept");

endmodule
